@@ sv/cursor_text_list_editor_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the cursor text list editor
// Shared concurrent check forms; the using scope provides clk and rst.
// ----------------------------------------------------------------------------
`ifndef CURSOR_TEXT_LIST_EDITOR_UNIT_MACROS_SVH
`define CURSOR_TEXT_LIST_EDITOR_UNIT_MACROS_SVH

// same-cycle implication
`define CTLE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CTLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/ctle_pkg.sv @@
// ----------------------------------------------------------------------------
// ctle_pkg
// Command and status codes and controller/datapath link types.
// ----------------------------------------------------------------------------
`default_nettype none

package ctle_pkg;

  localparam logic [2:0] CMD_INSERT    = 3'd0;
  localparam logic [2:0] CMD_LEFT      = 3'd1;
  localparam logic [2:0] CMD_RIGHT     = 3'd2;
  localparam logic [2:0] CMD_BACKSPACE = 3'd3;
  localparam logic [2:0] CMD_RESTART   = 3'd4;
  localparam logic [2:0] CMD_READ      = 3'd5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic idle;    // ready for a new word
    logic rd;      // memory read phase
    logic wr1;     // first link write phase
    logic wr2;     // second link write phase (insert only)
    logic finish;  // result phase
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic take;      // input word offered
    logic skip;      // offered word needs no memory access
    logic link2;     // latched word needs the second write phase
    logic out_free;  // output register can load
  } stat_t;

endpackage

`default_nettype wire

@@ sv/ctle_in_if.sv @@
// ----------------------------------------------------------------------------
// ctle_in_if
// Command channel: valid/ready with command and character byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface ctle_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [7:0] char_in;

  modport source (output valid, output command, output char_in, input ready);
  modport sink   (input valid, input command, input char_in, output ready);
endinterface

`default_nettype wire

@@ sv/ctle_out_if.sv @@
// ----------------------------------------------------------------------------
// ctle_out_if
// Result channel: valid/ready with read character, flags and status.
// ----------------------------------------------------------------------------
`default_nettype none

interface ctle_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       char_valid;
  logic       last;
  logic [1:0] status;

  modport source (output valid, output char_out, output char_valid, output last,
                  output status, input ready);
  modport sink   (input valid, input char_out, input char_valid, input last,
                  input status, output ready);
endinterface

`default_nettype wire

@@ sv/ctle_ctrl.sv @@
// ----------------------------------------------------------------------------
// ctle_ctrl
// Phase sequencer: idle, memory read, link writes, result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cursor_text_list_editor_unit_macros.svh"

module ctle_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire ctle_pkg::stat_t stat,
  output ctle_pkg::ctl_t       ctl
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_READ   = 5'b00010,
    S_LINK1  = 5'b00100,
    S_LINK2  = 5'b01000,
    S_RESULT = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (stat.take) begin
          state_next = stat.skip ? S_RESULT : S_READ;
        end
      end
      S_READ:  state_next = S_LINK1;
      S_LINK1: state_next = stat.link2 ? S_LINK2 : S_RESULT;
      S_LINK2: state_next = S_RESULT;
      S_RESULT: begin
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign ctl.idle   = (state == S_IDLE);
  assign ctl.rd     = (state == S_READ);
  assign ctl.wr1    = (state == S_LINK1);
  assign ctl.wr2    = (state == S_LINK2);
  assign ctl.finish = (state == S_RESULT);

  `CTLE_ASSERT_NEXT(a_read_then_link, state == S_READ, state == S_LINK1, "read not followed by link")
  `CTLE_ASSERT_NEXT(a_link2_then_result, state == S_LINK2, state == S_RESULT, "link2 not followed by result")
  `CTLE_ASSERT_NEXT(a_result_holds, (state == S_RESULT) && !stat.out_free, state == S_RESULT, "result dropped while output busy")

endmodule

`default_nettype wire

@@ sv/ctle_dp.sv @@
// ----------------------------------------------------------------------------
// ctle_dp
// Node memories, pointer registers, command decode and output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cursor_text_list_editor_unit_macros.svh"

module ctle_dp #(
  parameter int unsigned POOL_NODES = 1024
) (
  input  wire logic           clk,
  input  wire logic           rst,
  ctle_in_if.sink             req,
  ctle_out_if.source          rsp,
  input  wire ctle_pkg::ctl_t ctl,
  output ctle_pkg::stat_t     stat
);

  localparam int PW = $clog2(POOL_NODES);
  localparam int CW = $clog2(POOL_NODES + 1);

  // pointer state
  logic [PW-1:0] tail_ptr, cursor_ptr, read_ptr;
  logic [CW-1:0] alloc_count;

  // latched word and result bookkeeping
  logic [2:0] cmd_q;
  logic [7:0] ch_q;
  logic [1:0] status_q;
  logic       hit_q;
  logic       last_q;

  // output register
  logic       out_valid;
  logic [7:0] out_char;
  logic       out_char_valid;
  logic       out_last;
  logic [1:0] out_status;

  // node memories, single port each, registered read
  logic [7:0]    node_char [POOL_NODES];
  logic [PW-1:0] node_next [POOL_NODES];
  logic [PW-1:0] node_prev [POOL_NODES];

  logic [PW-1:0] char_addr, next_addr, prev_addr;
  logic          char_we, char_re, next_we, next_re, prev_we, prev_re;
  logic [7:0]    char_wd, char_rd;
  logic [PW-1:0] next_wd, next_rd, prev_wd, prev_rd;

  logic [PW-1:0] new_node;
  logic          full, at_tail, at_head, out_free, take;
  logic          skip;
  logic [1:0]    skip_status;

  assign new_node = alloc_count[PW-1:0];
  assign full     = (alloc_count >= CW'(POOL_NODES));
  assign at_tail  = (cursor_ptr == tail_ptr);
  assign at_head  = (cursor_ptr == '0);
  assign out_free = !out_valid || rsp.ready;
  assign take     = ctl.idle && req.valid;

  assign req.ready = ctl.idle;

  // words finished without touching memory
  always_comb begin
    skip        = 1'b1;
    skip_status = ctle_pkg::ST_IGNORED;
    case (req.command)
      ctle_pkg::CMD_INSERT: begin
        skip        = full;
        skip_status = full ? ctle_pkg::ST_FULL : ctle_pkg::ST_OK;
      end
      ctle_pkg::CMD_LEFT, ctle_pkg::CMD_BACKSPACE: begin
        skip        = at_head;
        skip_status = at_head ? ctle_pkg::ST_IGNORED : ctle_pkg::ST_OK;
      end
      ctle_pkg::CMD_RIGHT: begin
        skip        = at_tail;
        skip_status = at_tail ? ctle_pkg::ST_IGNORED : ctle_pkg::ST_OK;
      end
      ctle_pkg::CMD_RESTART: begin
        skip        = 1'b1;
        skip_status = ctle_pkg::ST_OK;
      end
      ctle_pkg::CMD_READ: begin
        skip        = (read_ptr == tail_ptr);
        skip_status = skip ? ctle_pkg::ST_IGNORED : ctle_pkg::ST_OK;
      end
      default: begin
        skip        = 1'b1;
        skip_status = ctle_pkg::ST_IGNORED;
      end
    endcase
  end

  assign stat.take     = req.valid;
  assign stat.skip     = skip;
  assign stat.link2    = (cmd_q == ctle_pkg::CMD_INSERT);
  assign stat.out_free = out_free;

  // memory port control per phase
  always_comb begin
    char_we = 1'b0; char_re = 1'b0; char_addr = cursor_ptr; char_wd = ch_q;
    next_we = 1'b0; next_re = 1'b0; next_addr = cursor_ptr; next_wd = '0;
    prev_we = 1'b0; prev_re = 1'b0; prev_addr = cursor_ptr; prev_wd = '0;
    if (ctl.rd) begin
      case (cmd_q)
        ctle_pkg::CMD_INSERT: begin
          next_re   = 1'b1;
          char_we   = 1'b1;
          char_addr = new_node;
          prev_we   = 1'b1;
          prev_addr = new_node;
          prev_wd   = cursor_ptr;
        end
        ctle_pkg::CMD_LEFT:  prev_re = 1'b1;
        ctle_pkg::CMD_RIGHT: next_re = 1'b1;
        ctle_pkg::CMD_BACKSPACE: begin
          prev_re = 1'b1;
          next_re = 1'b1;
        end
        ctle_pkg::CMD_READ: begin
          next_re   = 1'b1;
          next_addr = read_ptr;
        end
        default: ;
      endcase
    end else if (ctl.wr1) begin
      case (cmd_q)
        ctle_pkg::CMD_INSERT: begin
          next_we   = 1'b1;
          next_addr = new_node;
          next_wd   = at_tail ? '0 : next_rd;
          prev_we   = !at_tail;
          prev_addr = next_rd;
          prev_wd   = new_node;
        end
        ctle_pkg::CMD_BACKSPACE: begin
          next_we   = 1'b1;
          next_addr = prev_rd;
          next_wd   = at_tail ? '0 : next_rd;
          prev_we   = !at_tail;
          prev_addr = next_rd;
          prev_wd   = prev_rd;
        end
        ctle_pkg::CMD_READ: begin
          char_re   = (next_rd != '0);
          char_addr = next_rd;
        end
        default: ;
      endcase
    end else if (ctl.wr2) begin
      next_we   = 1'b1;
      next_addr = cursor_ptr;
      next_wd   = new_node;
    end
  end

  always_ff @(posedge clk) begin
    if (char_we) node_char[char_addr] <= char_wd;
    if (char_re) char_rd <= node_char[char_addr];
  end

  always_ff @(posedge clk) begin
    if (next_we) node_next[next_addr] <= next_wd;
    if (next_re) next_rd <= node_next[next_addr];
  end

  always_ff @(posedge clk) begin
    if (prev_we) node_prev[prev_addr] <= prev_wd;
    if (prev_re) prev_rd <= node_prev[prev_addr];
  end

  // pointer state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      tail_ptr    <= '0;
      cursor_ptr  <= '0;
      read_ptr    <= '0;
      alloc_count <= CW'(1);
      out_valid   <= 1'b0;
    end else begin
      if (take && (req.command == ctle_pkg::CMD_RESTART)) begin
        read_ptr <= '0;
      end
      if (ctl.wr1) begin
        case (cmd_q)
          ctle_pkg::CMD_LEFT:  cursor_ptr <= prev_rd;
          ctle_pkg::CMD_RIGHT: cursor_ptr <= next_rd;
          ctle_pkg::CMD_BACKSPACE: begin
            cursor_ptr <= prev_rd;
            if (at_tail) tail_ptr <= prev_rd;
          end
          ctle_pkg::CMD_READ: begin
            if (next_rd != '0) read_ptr <= next_rd;
          end
          default: ;
        endcase
      end
      if (ctl.wr2) begin
        cursor_ptr  <= new_node;
        alloc_count <= alloc_count + CW'(1);
        if (at_tail) tail_ptr <= new_node;
      end
      if (rsp.valid && rsp.ready) out_valid <= 1'b0;
      if (ctl.finish && out_free) out_valid <= 1'b1;
    end
  end

  // latched word, result flags and output payload
  always_ff @(posedge clk) begin
    if (take) begin
      cmd_q    <= req.command;
      ch_q     <= req.char_in;
      status_q <= skip_status;
      hit_q    <= 1'b0;
      last_q   <= 1'b0;
    end
    if (ctl.wr1 && (cmd_q == ctle_pkg::CMD_READ)) begin
      if (next_rd == '0) begin
        status_q <= ctle_pkg::ST_IGNORED;
      end else begin
        hit_q  <= 1'b1;
        last_q <= (next_rd == tail_ptr);
      end
    end
    if (ctl.finish && out_free) begin
      out_char       <= hit_q ? char_rd : 8'd0;
      out_char_valid <= hit_q;
      out_last       <= hit_q && last_q;
      out_status     <= status_q;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.char_out   = out_char;
  assign rsp.char_valid = out_char_valid;
  assign rsp.last       = out_last;
  assign rsp.status     = out_status;

  `CTLE_ASSERT_NOW(a_alloc_range, 1'b1, alloc_count <= CW'(POOL_NODES), "alloc count past pool")
  `CTLE_ASSERT_NOW(a_empty_cursor, tail_ptr == '0, cursor_ptr == '0, "cursor off sentinel in empty list")
  `CTLE_ASSERT_NOW(a_char_ok, rsp.valid && rsp.char_valid, rsp.status == ctle_pkg::ST_OK, "read char with bad status")

endmodule

`default_nettype wire

@@ sv/cursor_text_list_editor_unit.sv @@
// ----------------------------------------------------------------------------
// cursor_text_list_editor_unit
// Text buffer as a doubly linked list in a node pool, edited at a cursor.
// ----------------------------------------------------------------------------
// Each command word on req gives exactly one result word on rsp. Node 0 is a
// head sentinel; the cursor sits on the node just after which the next insert
// lands. Nodes come from a bump counter and are never reused, so after
// POOL_NODES-1 inserts every insert is refused with status 2. Words that need
// no memory access (restart, unused codes, full pool, moves/backspace/read at
// a boundary) go from idle straight to the result phase; left, right,
// backspace and read pass through a read phase and one link-write phase,
// insert through a read phase and two link-write phases. The result phase
// waits until the output register is free, loads it and returns to idle,
// where the next word is accepted. The phases follow from the three
// single-port node memories with registered read: an insert rewrites two
// next links in the same memory, hence its second link-write phase. One word
// is in flight at a time; a new word is accepted while the previous result
// still waits in the output register. The node memories need no clearing
// after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module cursor_text_list_editor_unit #(
  parameter int unsigned POOL_NODES = 1024
) (
  input  wire logic clk,
  input  wire logic rst,
  ctle_in_if.sink    req,
  ctle_out_if.source rsp
);

  ctle_pkg::ctl_t  ctl;   // phase strobes from the sequencer
  ctle_pkg::stat_t stat;  // decode and handshake status back to it

  // sequencer: idle -> (read -> link1 -> (link2)) -> result
  ctle_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctl  (ctl)
  );

  // memories, pointers and output register
  ctle_dp #(
    .POOL_NODES (POOL_NODES)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .rsp  (rsp),
    .ctl  (ctl),
    .stat (stat)
  );

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the cursor text list editor.
// ----------------------------------------------------------------------------
// A queue of command words is built up front: a short hand-written sequence
// of boundary and edit cases, then random edits that fill the node pool to
// the point where inserts are refused, with readout bursts mixed in. A clocked
// driver feeds the words with random gaps. A shadow copy of the linked list
// computes the expected result word whenever a command is accepted. A clocked
// monitor takes result words with random stalls and one long hold-off, and
// compares every field against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POOL = 1024;
  localparam int RANDOM_ITEMS = 1000;
  localparam int POST_FULL_ITEMS = 60;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_REPORTS = 10;

  // codes the block answers with "ignored"
  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] ch;
  } edit_cmd_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       ch_valid;
    logic       last;
    logic [1:0] status;
  } edit_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ctle_in_if  req_if();
  ctle_out_if rsp_if();

  cursor_text_list_editor_unit #(
    .POOL_NODES(POOL)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  always #6 clk = ~clk;

  // --------------------------------------------------------------------------
  // Shadow of the text buffer. Pointers are node indexes; node 0 is the head
  // sentinel and a next link of 0 means "end of list".
  // --------------------------------------------------------------------------
  logic [7:0]  text_char [POOL];
  logic [9:0]  next_link [POOL];
  logic [9:0]  prev_link [POOL];
  logic [9:0]  tail_node = '0;
  logic [9:0]  cursor_node = '0;
  logic [9:0]  read_node = '0;
  logic [10:0] next_free = 11'd1;

  edit_cmd_t    cmd_backlog[$];
  edit_result_t expected_words[$];

  int total_words = 0;
  int inserts_queued = 0;
  int words_checked = 0;
  int mismatches = 0;
  int gap_left = 0;
  int stall_left = 0;
  logic hold_off = 1'b0;

  // Applies one command to the shadow list and returns the result word.
  function automatic edit_result_t apply_edit(input logic [2:0] op, input logic [7:0] c);
    edit_result_t r;
    logic [9:0] fresh;
    logic [9:0] cur;
    logic [9:0] after;
    logic [9:0] prior;
    r = '0;
    r.status = ctle_pkg::ST_OK;
    cur = cursor_node;
    case (op)
      ctle_pkg::CMD_INSERT: begin
        if (next_free >= 11'(POOL)) begin
          r.status = ctle_pkg::ST_FULL;
        end else begin
          fresh = next_free[9:0];
          next_free = next_free + 11'd1;
          text_char[fresh] = c;
          prev_link[fresh] = cur;
          if (cur == tail_node) begin
            next_link[fresh] = '0;
            next_link[cur] = fresh;
            tail_node = fresh;
          end else begin
            after = next_link[cur];
            next_link[fresh] = after;
            prev_link[after] = fresh;
            next_link[cur] = fresh;
          end
          cursor_node = fresh;
        end
      end
      ctle_pkg::CMD_LEFT: begin
        if (cur == '0) r.status = ctle_pkg::ST_IGNORED;
        else cursor_node = prev_link[cur];
      end
      ctle_pkg::CMD_RIGHT: begin
        if (cur == tail_node) r.status = ctle_pkg::ST_IGNORED;
        else cursor_node = next_link[cur];
      end
      ctle_pkg::CMD_BACKSPACE: begin
        if (cur == '0) begin
          r.status = ctle_pkg::ST_IGNORED;
        end else begin
          prior = prev_link[cur];
          if (cur == tail_node) begin
            // new tail must not keep pointing at the removed node
            next_link[prior] = '0;
            tail_node = prior;
          end else begin
            after = next_link[cur];
            next_link[prior] = after;
            prev_link[after] = prior;
          end
          cursor_node = prior;
        end
      end
      ctle_pkg::CMD_RESTART: begin
        read_node = '0;
      end
      ctle_pkg::CMD_READ: begin
        // a read pointer left on a deleted node follows its stale next link
        after = next_link[read_node];
        if (read_node == tail_node || after == '0) begin
          r.status = ctle_pkg::ST_IGNORED;
        end else begin
          read_node = after;
          r.ch = text_char[after];
          r.ch_valid = 1'b1;
          r.last = (after == tail_node);
        end
      end
      default: begin
        r.status = ctle_pkg::ST_IGNORED;
      end
    endcase
    return r;
  endfunction

  task automatic queue_cmd(input logic [2:0] op, input logic [7:0] c);
    edit_cmd_t w;
    w.op = op;
    w.ch = c;
    cmd_backlog.push_back(w);
    total_words++;
    if (op == ctle_pkg::CMD_INSERT) inserts_queued++;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus: directed cases, then random edits until the pool has been full
  // for a while.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int k;
    int roll;
    int burst;
    int post_full;
    logic full;
    logic [2:0] op;

    // empty buffer: everything at a boundary
    queue_cmd(ctle_pkg::CMD_READ, 8'h11);
    queue_cmd(ctle_pkg::CMD_LEFT, 8'h22);
    queue_cmd(ctle_pkg::CMD_RIGHT, 8'h33);
    queue_cmd(ctle_pkg::CMD_BACKSPACE, 8'h44);
    queue_cmd(CMD_SPARE6, 8'h55);
    queue_cmd(CMD_SPARE7, 8'hAA);
    // three characters at the tail, then read them all and past the end
    queue_cmd(ctle_pkg::CMD_INSERT, 8'h00);
    queue_cmd(ctle_pkg::CMD_INSERT, 8'hFF);
    queue_cmd(ctle_pkg::CMD_INSERT, 8'hA5);
    queue_cmd(ctle_pkg::CMD_RESTART, 8'h00);
    queue_cmd(ctle_pkg::CMD_READ, 8'h00);
    queue_cmd(ctle_pkg::CMD_READ, 8'hFF);
    queue_cmd(ctle_pkg::CMD_READ, 8'h00);
    queue_cmd(ctle_pkg::CMD_READ, 8'hFF);
    // park the reader on the first node, then delete it and the middle one
    queue_cmd(ctle_pkg::CMD_RESTART, 8'h7F);
    queue_cmd(ctle_pkg::CMD_READ, 8'h80);
    queue_cmd(ctle_pkg::CMD_LEFT, 8'h01);
    queue_cmd(ctle_pkg::CMD_BACKSPACE, 8'hFE);
    queue_cmd(ctle_pkg::CMD_BACKSPACE, 8'h01);
    queue_cmd(ctle_pkg::CMD_READ, 8'h00);
    // cursor on the sentinel, walk to the tail and delete it
    queue_cmd(ctle_pkg::CMD_LEFT, 8'h00);
    queue_cmd(ctle_pkg::CMD_RIGHT, 8'h00);
    queue_cmd(ctle_pkg::CMD_RIGHT, 8'h00);
    queue_cmd(ctle_pkg::CMD_BACKSPACE, 8'h00);
    queue_cmd(ctle_pkg::CMD_INSERT, 8'h3C);

    k = 0;
    post_full = 0;
    while (k < RANDOM_ITEMS || post_full < POST_FULL_ITEMS) begin
      full = (inserts_queued >= POOL - 1);
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
        // readout pass from the top
        queue_cmd(ctle_pkg::CMD_RESTART, 8'($urandom_range(0, 255)));
        burst = $urandom_range(3, 8);
        repeat (burst) queue_cmd(ctle_pkg::CMD_READ, 8'($urandom_range(0, 255)));
        k += burst + 1;
      end else begin
        if (!full) begin
          if (roll < 91) op = ctle_pkg::CMD_INSERT;
          else if (roll < 93) op = ctle_pkg::CMD_LEFT;
          else if (roll < 95) op = ctle_pkg::CMD_RIGHT;
          else if (roll < 97) op = ctle_pkg::CMD_BACKSPACE;
          else if (roll < 98) op = ctle_pkg::CMD_READ;
          else if (roll == 98) op = CMD_SPARE6;
          else op = CMD_SPARE7;
        end else begin
          if (roll < 15) op = ctle_pkg::CMD_INSERT;
          else if (roll < 38) op = ctle_pkg::CMD_LEFT;
          else if (roll < 61) op = ctle_pkg::CMD_RIGHT;
          else if (roll < 80) op = ctle_pkg::CMD_BACKSPACE;
          else if (roll < 96) op = ctle_pkg::CMD_READ;
          else if (roll < 98) op = ctle_pkg::CMD_RESTART;
          else if (roll == 98) op = CMD_SPARE6;
          else op = CMD_SPARE7;
        end
        queue_cmd(op, 8'($urandom_range(0, 255)));
        k++;
      end
      if (full) post_full++;
    end
  end

  // --------------------------------------------------------------------------
  // Driver: presents one word at a time, predicts on acceptance, and waits a
  // random gap after each word.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    edit_cmd_t w;
    if (rst) begin
      req_if.valid <= 1'b0;
      req_if.command <= ctle_pkg::CMD_RESTART;
      req_if.char_in <= '0;
      gap_left <= 0;
    end else begin
      if (req_if.valid && req_if.ready)
        expected_words.push_back(apply_edit(req_if.command, req_if.char_in));
      if (!req_if.valid || req_if.ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          req_if.valid <= 1'b0;
        end else if (cmd_backlog.size() != 0) begin
          w = cmd_backlog.pop_front();
          req_if.valid <= 1'b1;
          req_if.command <= w.op;
          req_if.char_in <= w.ch;
          // at least half the words go back to back
          gap_left <= ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 5);
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: random stall after each result word, plus the long hold-off.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    edit_result_t got;
    edit_result_t want;
    int stall_next;
    if (rst) begin
      rsp_if.ready <= 1'b0;
      stall_left <= 0;
    end else begin
      stall_next = stall_left;
      if (rsp_if.valid && rsp_if.ready) begin
        got.ch = rsp_if.char_out;
        got.ch_valid = rsp_if.char_valid;
        got.last = rsp_if.last;
        got.status = rsp_if.status;
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("[%0t] unexpected result word: char %02h cv %0b last %0b status %0d",
                     $realtime, got.ch, got.ch_valid, got.last, got.status);
        end else begin
          want = expected_words.pop_front();
          if (got.ch != want.ch || got.ch_valid != want.ch_valid ||
              got.last != want.last || got.status != want.status) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("[%0t] word %0d mismatch: char %02h/%02h cv %0b/%0b ",
                       $realtime, words_checked, want.ch, got.ch, want.ch_valid,
                       got.ch_valid, "last %0b/%0b status %0d/%0d (expected/actual)",
                       want.last, got.last, want.status, got.status);
          end
        end
        words_checked <= words_checked + 1;
        stall_next = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 5);
      end else if (stall_next != 0) begin
        stall_next = stall_next - 1;
      end
      stall_left <= stall_next;
      rsp_if.ready <= (stall_next == 0) && !hold_off;
    end
  end

  // Long receiver hold-off so the block backs up and stalls its input.
  initial begin : backpressure
    wait (words_checked >= 200);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // Reset, end of run and verdict.
  // --------------------------------------------------------------------------
  initial begin : run_control
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (words_checked < total_words) @(posedge clk);
    // drain window before the verdict
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire
